FILE: design/bsdf_pkg.sv
// Package for the breakable spring-damper force block.
// Holds widths, register codes, the configuration struct and the
// controller-to-datapath command and datapath-to-controller status structs. No dependencies.
package bsdf_pkg;

    // Default parameter values.
    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed widths.
    localparam int REG_W   = 24;
    localparam int FORCE_W = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Iteration counts of the square root unit and the divider.
    localparam int SQRT_STEPS = REG_W + 1;
    localparam int DIV_STEPS  = REG_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    // Register indices.
    typedef enum logic [2:0] {
        REG_REST_LENGTH = 3'd0,
        REG_STIFFNESS   = 3'd1,
        REG_DAMPING     = 3'd2,
        REG_MIN_BREAK   = 3'd3,
        REG_MAX_BREAK   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] rest_length;
        logic [REG_W-1:0] stiffness;
        logic [REG_W-1:0] damping;
        logic [REG_W-1:0] min_break;
        logic [REG_W-1:0] max_break;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       sq_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       range_latch;
        logic       prod_load;
        logic       div_step;
        logic       kmul;
        logic       cmul;
        logic       comb;
        logic       set_broken;
        logic [1:0] idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic long_break;
        logic range_break;
    } status_t;

endpackage

FILE: design/breakable_spring_damper_force_top.sv
// Breakable spring-damper force block: one result word per input word.
// An intact spring runs a square root of 25 steps and 3 x 24 division steps;
// the length range check can break it after the square root, and a broken
// spring or a too-long component goes straight to the result.
// One word in flight: the next word is taken no earlier than the cycle after
// the result is taken.
// Synchronous active-low reset: registers to defaults, spring intact, idle.
module breakable_spring_damper_force_top #(
    parameter int COORD_WIDTH = bsdf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = bsdf_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsdf_pkg::ADDR_W-1:0]         paddr,
    input  logic [bsdf_pkg::DATA_W-1:0]         pwdata,
    output logic [bsdf_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_WIDTH-1:0]       s_first_pos_x,
    input  logic signed [COORD_WIDTH-1:0]       s_first_pos_y,
    input  logic signed [COORD_WIDTH-1:0]       s_first_pos_z,
    input  logic signed [COORD_WIDTH-1:0]       s_second_pos_x,
    input  logic signed [COORD_WIDTH-1:0]       s_second_pos_y,
    input  logic signed [COORD_WIDTH-1:0]       s_second_pos_z,
    input  logic signed [COORD_WIDTH-1:0]       s_first_vel_x,
    input  logic signed [COORD_WIDTH-1:0]       s_first_vel_y,
    input  logic signed [COORD_WIDTH-1:0]       s_first_vel_z,
    input  logic signed [COORD_WIDTH-1:0]       s_second_vel_x,
    input  logic signed [COORD_WIDTH-1:0]       s_second_vel_y,
    input  logic signed [COORD_WIDTH-1:0]       s_second_vel_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bsdf_pkg::FORCE_W-1:0] m_force_x,
    output logic signed [bsdf_pkg::FORCE_W-1:0] m_force_y,
    output logic signed [bsdf_pkg::FORCE_W-1:0] m_force_z,
    output logic                                m_broken,
    output logic                                m_force_saturated
);
    import bsdf_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;
    logic signed [COORD_WIDTH-1:0] p1 [3];
    logic signed [COORD_WIDTH-1:0] p2 [3];
    logic signed [COORD_WIDTH-1:0] v1 [3];
    logic signed [COORD_WIDTH-1:0] v2 [3];
    logic signed [FORCE_W-1:0]     force_out [3];

    // Gather the vector components.
    assign p1 = '{s_first_pos_x, s_first_pos_y, s_first_pos_z};
    assign p2 = '{s_second_pos_x, s_second_pos_y, s_second_pos_z};
    assign v1 = '{s_first_vel_x, s_first_vel_y, s_first_vel_z};
    assign v2 = '{s_second_vel_x, s_second_vel_y, s_second_vel_z};

    bsdf_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    bsdf_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .status, .cmd
    );

    bsdf_dp #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .cmd, .status, .cfg, .p1, .p2, .v1, .v2,
        .force_out, .broken(m_broken), .saturated(m_force_saturated)
    );

    assign m_force_x = force_out[0];
    assign m_force_y = force_out[1];
    assign m_force_z = force_out[2];

endmodule

FILE: design/bsdf_regs.sv
// APB register file for the spring parameters.
// Depends on bsdf_pkg.
module bsdf_regs #(
    parameter int FRAC_BITS = bsdf_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsdf_pkg::ADDR_W-1:0] paddr,
    input  logic [bsdf_pkg::DATA_W-1:0] pwdata,
    output logic [bsdf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output bsdf_pkg::cfg_t              cfg
);
    import bsdf_pkg::*;

    localparam logic [REG_W-1:0] REST_RST = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] MIN_RST  =
        REG_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [REG_W-1:0] MAX_RST  = REG_W'(64'd2 << FRAC_BITS);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_REST_LENGTH: cfg_next.rest_length = pwdata[REG_W-1:0];
                REG_STIFFNESS:   cfg_next.stiffness   = pwdata[REG_W-1:0];
                REG_DAMPING:     cfg_next.damping     = pwdata[REG_W-1:0];
                REG_MIN_BREAK:   cfg_next.min_break   = pwdata[REG_W-1:0];
                REG_MAX_BREAK:   cfg_next.max_break   = pwdata[REG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_length <= REST_RST;
            cfg_reg.stiffness   <= REST_RST;
            cfg_reg.damping     <= '0;
            cfg_reg.min_break   <= MIN_RST;
            cfg_reg.max_break   <= MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back.
    always_comb begin
        case (idx)
            REG_REST_LENGTH: prdata = DATA_W'(cfg_reg.rest_length);
            REG_STIFFNESS:   prdata = DATA_W'(cfg_reg.stiffness);
            REG_DAMPING:     prdata = DATA_W'(cfg_reg.damping);
            REG_MIN_BREAK:   prdata = DATA_W'(cfg_reg.min_break);
            REG_MAX_BREAK:   prdata = DATA_W'(cfg_reg.max_break);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: design/bsdf_ctrl.sv
// Controller state machine: sequences the check, square root, division
// and per-axis force steps. Holds the sticky intact flag. Depends on bsdf_pkg.
module bsdf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  bsdf_pkg::status_t   status,
    output bsdf_pkg::cmd_t      cmd
);
    import bsdf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SQ, ST_SQI, ST_SQRT, ST_RANGE,
        ST_PROD, ST_DIV, ST_KMUL, ST_CMUL, ST_COMB, ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             intact_reg, intact_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // Next state and command decode.
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        intact_next = intact_reg;
        cmd         = '0;
        cmd.idx     = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!intact_reg || status.long_break) begin
                    intact_next    = 1'b0;
                    cmd.set_broken = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    idx_next   = 2'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_step = 1'b1;
                if (idx_reg == 2'd2) begin
                    state_next = ST_SQI;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_SQI: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                if (status.range_break) begin
                    intact_next    = 1'b0;
                    cmd.set_broken = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    cmd.range_latch = 1'b1;
                    idx_next        = 2'd0;
                    state_next      = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod_load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_KMUL;
                end
            end
            ST_KMUL: begin
                cmd.kmul   = 1'b1;
                state_next = ST_CMUL;
            end
            ST_CMUL: begin
                cmd.cmul   = 1'b1;
                state_next = ST_COMB;
            end
            ST_COMB: begin
                cmd.comb = 1'b1;
                if (idx_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_PROD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            intact_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            intact_reg <= intact_next;
        end
    end

endmodule

FILE: design/bsdf_dp.sv
// Datapath: differences, shared multiplier, bit-serial square root,
// restoring divider and saturating force combine. Depends on bsdf_pkg.
module bsdf_dp #(
    parameter int COORD_WIDTH = bsdf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = bsdf_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  bsdf_pkg::cmd_t                       cmd,
    output bsdf_pkg::status_t                    status,
    input  bsdf_pkg::cfg_t                       cfg,
    input  logic signed [COORD_WIDTH-1:0]        p1 [3],
    input  logic signed [COORD_WIDTH-1:0]        p2 [3],
    input  logic signed [COORD_WIDTH-1:0]        v1 [3],
    input  logic signed [COORD_WIDTH-1:0]        v2 [3],
    output logic signed [bsdf_pkg::FORCE_W-1:0]  force_out [3],
    output logic                                 broken,
    output logic                                 saturated
);
    import bsdf_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int CMPW = (DW > REG_W) ? DW : REG_W;
    localparam int PW   = REG_W + CMPW;
    localparam int AW   = 2 * REG_W + 2;
    localparam int SW   = 2 * REG_W - FRAC_BITS;
    localparam int FW   = PW - FRAC_BITS;
    localparam int TW   = FW + 2;
    localparam logic signed [TW-1:0] FMAX = TW'(64'h7FFF_FFFF);
    localparam logic signed [TW-1:0] FMIN = ~FMAX;

    logic signed [DW-1:0]  d_reg  [3];
    logic signed [DW-1:0]  dv_reg [3];
    logic [AW-1:0]         acc_reg;
    logic [AW-1:0]         rad_reg;
    logic [REG_W+2:0]      srem_reg;
    logic [REG_W:0]        root_reg;
    logic [REG_W-1:0]      r_reg;
    logic [REG_W-1:0]      rl_reg;
    logic                  rlneg_reg;
    logic [REG_W-1:0]      drem_reg;
    logic [REG_W-1:0]      dq_reg;
    logic [SW-1:0]         s_reg;
    logic [FW-1:0]         f_reg;
    logic signed [FORCE_W-1:0] force_reg [3];
    logic                  broken_reg;
    logic                  sat_reg;

    logic signed [DW-1:0]  dsel, dvsel;
    logic [CMPW-1:0]       dmag_sel, dvmag_sel;
    logic [CMPW-1:0]       dmag [3];
    logic [CMPW-1:0]       max_ext;
    logic [REG_W-1:0]      mul_a;
    logic [CMPW-1:0]       mul_b;
    logic [PW-1:0]         prod;
    logic [REG_W+4:0]      sq_rt, sq_trial;
    logic [REG_W:0]        dv_t;
    logic [REG_W+1:0]      root_ext;
    logic [REG_W+1:0]      min_ext, max_ext2;
    logic signed [TW-1:0]  sv, fv, tot;

    function automatic logic [CMPW-1:0] absval(input logic signed [DW-1:0] x);
        logic [DW-1:0] m;
        m = x[DW-1] ? DW'(-x) : DW'(x);
        return CMPW'(m);
    endfunction

    // Length limits, widened to the magnitude and square root result widths.
    assign max_ext  = CMPW'(cfg.max_break);
    assign root_ext = (REG_W + 2)'(root_reg);
    assign min_ext  = (REG_W + 2)'(cfg.min_break);
    assign max_ext2 = (REG_W + 2)'(cfg.max_break);

    // Long-component check on the magnitudes and range check on the root.
    always_comb begin
        status.long_break  = 1'b0;
        status.range_break = (root_ext <= min_ext) || (root_ext >= max_ext2);
        for (int i = 0; i < 3; i++) begin
            dmag[i] = absval(d_reg[i]);
            if (dmag[i] >= max_ext) begin
                status.long_break = 1'b1;
            end
        end
    end

    assign dsel      = d_reg[cmd.idx];
    assign dvsel     = dv_reg[cmd.idx];
    assign dmag_sel  = absval(dsel);
    assign dvmag_sel = absval(dvsel);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = dmag_sel[REG_W-1:0];
        mul_b = CMPW'(dmag_sel[REG_W-1:0]);
        if (cmd.prod_load) begin
            mul_b = CMPW'(rl_reg);
        end else if (cmd.kmul) begin
            mul_a = cfg.stiffness;
            mul_b = CMPW'(dq_reg);
        end else if (cmd.cmul) begin
            mul_a = cfg.damping;
            mul_b = dvmag_sel;
        end
    end
    assign prod = PW'(mul_a) * PW'(mul_b);

    // One square root digit per step.
    assign sq_rt    = {srem_reg, rad_reg[AW-1:AW-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // One quotient bit per step.
    assign dv_t = {drem_reg, dq_reg[REG_W-1]};

    // Signed force combine.
    always_comb begin
        sv  = TW'(s_reg);
        if (d_reg[cmd.idx][DW-1] != rlneg_reg) begin
            sv = -sv;
        end
        fv  = TW'(f_reg);
        if (dvsel[DW-1]) begin
            fv = -fv;
        end
        tot = -sv - fv;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i]  <= DW'(p1[i]) - DW'(p2[i]);
                dv_reg[i] <= DW'(v1[i]) - DW'(v2[i]);
            end
            acc_reg    <= '0;
            broken_reg <= 1'b0;
            sat_reg    <= 1'b0;
        end
        if (cmd.sq_step) begin
            acc_reg <= acc_reg + AW'(prod[2*REG_W-1:0]);
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= acc_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[AW-3:0], 2'b00};
            if (sq_rt >= sq_trial) begin
                srem_reg <= (REG_W + 3)'(sq_rt - sq_trial);
                root_reg <= {root_reg[REG_W-1:0], 1'b1};
            end else begin
                srem_reg <= (REG_W + 3)'(sq_rt);
                root_reg <= {root_reg[REG_W-1:0], 1'b0};
            end
        end
        if (cmd.range_latch) begin
            r_reg <= root_reg[REG_W-1:0];
            if (root_reg[REG_W-1:0] < cfg.rest_length) begin
                rl_reg    <= cfg.rest_length - root_reg[REG_W-1:0];
                rlneg_reg <= 1'b1;
            end else begin
                rl_reg    <= root_reg[REG_W-1:0] - cfg.rest_length;
                rlneg_reg <= 1'b0;
            end
        end
        if (cmd.prod_load) begin
            drem_reg <= prod[2*REG_W-1:REG_W];
            dq_reg   <= prod[REG_W-1:0];
        end
        if (cmd.div_step) begin
            if (dv_t >= {1'b0, r_reg}) begin
                drem_reg <= REG_W'(dv_t - {1'b0, r_reg});
                dq_reg   <= {dq_reg[REG_W-2:0], 1'b1};
            end else begin
                drem_reg <= dv_t[REG_W-1:0];
                dq_reg   <= {dq_reg[REG_W-2:0], 1'b0};
            end
        end
        if (cmd.kmul) begin
            s_reg <= prod[2*REG_W-1:FRAC_BITS];
        end
        if (cmd.cmul) begin
            f_reg <= prod[PW-1:FRAC_BITS];
        end
        if (cmd.comb) begin
            if (tot > FMAX) begin
                force_reg[cmd.idx] <= FMAX[FORCE_W-1:0];
                sat_reg            <= 1'b1;
            end else if (tot < FMIN) begin
                force_reg[cmd.idx] <= FMIN[FORCE_W-1:0];
                sat_reg            <= 1'b1;
            end else begin
                force_reg[cmd.idx] <= tot[FORCE_W-1:0];
            end
        end
        if (cmd.set_broken) begin
            for (int i = 0; i < 3; i++) begin
                force_reg[i] <= '0;
            end
            broken_reg <= 1'b1;
            sat_reg    <= 1'b0;
        end
    end

    assign force_out = force_reg;
    assign broken    = broken_reg;
    assign saturated = sat_reg;

endmodule

FILE: design/bsdf_checker.sv
// Port-level checker for the spring-damper force block, bound to the top.
// Depends on bsdf_pkg.
module bsdf_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [bsdf_pkg::FORCE_W-1:0] m_force_x,
    input logic signed [bsdf_pkg::FORCE_W-1:0] m_force_y,
    input logic signed [bsdf_pkg::FORCE_W-1:0] m_force_z,
    input logic                                m_broken,
    input logic                                m_force_saturated
);
    import bsdf_pkg::*;

    logic seen_broken_reg;

    // Remember that a broken word has been delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_broken_reg <= 1'b0;
        end else if (m_valid && m_ready && m_broken) begin
            seen_broken_reg <= 1'b1;
        end
    end

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_x) && $stable(m_broken))
        else $error("stalled result changed");

    // A broken spring gives zero force and no saturation.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_broken |-> m_force_x == 0 && m_force_y == 0 &&
        m_force_z == 0 && !m_force_saturated)
        else $error("broken result carries force");

    // No new word is taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // Breaking is sticky until reset.
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_broken_reg |-> m_broken)
        else $error("spring mended itself");

endmodule

bind breakable_spring_damper_force_top bsdf_checker u_bsdf_checker (.*);
